// ----- hdl/vrbm_pkg.sv -----
// Shared constants, types and helper functions of the video RAM bank mapper.
package vrbm_pkg;

    // Address and block geometry
    localparam int ADDR_W      = 19;
    localparam int OFFS_W      = 17;
    localparam int NUM_BANKS   = 9;
    localparam int BANK_W      = 4;
    localparam int VIEW_W      = 4;
    localparam int CFG_AE_W    = 40;
    localparam int CFG_FI_W    = 32;
    localparam int BLOCK_BYTES = 16384;

    // Configuration register indexes
    localparam logic CFG_CTL_AE = 1'b0;
    localparam logic CFG_CTL_FI = 1'b1;

    // View codes
    localparam logic [VIEW_W-1:0] V_ABG   = 4'd0;
    localparam logic [VIEW_W-1:0] V_AOBJ  = 4'd1;
    localparam logic [VIEW_W-1:0] V_BBG   = 4'd2;
    localparam logic [VIEW_W-1:0] V_BOBJ  = 4'd3;
    localparam logic [VIEW_W-1:0] V_ABGX  = 4'd4;
    localparam logic [VIEW_W-1:0] V_BBGX  = 4'd5;
    localparam logic [VIEW_W-1:0] V_AOBJX = 4'd6;
    localparam logic [VIEW_W-1:0] V_BOBJX = 4'd7;
    localparam logic [VIEW_W-1:0] V_TEX   = 4'd8;
    localparam logic [VIEW_W-1:0] V_TPAL  = 4'd9;
    localparam logic [VIEW_W-1:0] V_ARM7  = 4'd10;

    // Bank indexes
    localparam logic [BANK_W-1:0] BK_A = 4'd0;
    localparam logic [BANK_W-1:0] BK_B = 4'd1;
    localparam logic [BANK_W-1:0] BK_C = 4'd2;
    localparam logic [BANK_W-1:0] BK_D = 4'd3;
    localparam logic [BANK_W-1:0] BK_E = 4'd4;
    localparam logic [BANK_W-1:0] BK_F = 4'd5;
    localparam logic [BANK_W-1:0] BK_G = 4'd6;
    localparam logic [BANK_W-1:0] BK_H = 4'd7;
    localparam logic [BANK_W-1:0] BK_I = 4'd8;

    // Address constants used by the mapping rules
    localparam logic [ADDR_W-1:0] SZ_8K   = 19'h02000;
    localparam logic [ADDR_W-1:0] SZ_16K  = 19'h04000;
    localparam logic [ADDR_W-1:0] SZ_32K  = 19'h08000;
    localparam logic [ADDR_W-1:0] SZ_48K  = 19'h0C000;
    localparam logic [ADDR_W-1:0] SZ_64K  = 19'h10000;
    localparam logic [ADDR_W-1:0] SZ_96K  = 19'h18000;
    localparam logic [ADDR_W-1:0] SZ_112K = 19'h1C000;
    localparam logic [ADDR_W-1:0] SZ_128K = 19'h20000;
    localparam logic [ADDR_W-1:0] SZ_256K = 19'h40000;
    localparam logic [ADDR_W-1:0] BLK_MASK = ADDR_W'(BLOCK_BYTES - 1);

    typedef logic [7:0] t_ctl;

    // Result of the decode for one word
    typedef struct packed {
        logic [NUM_BANKS-1:0] mask;
        logic [BANK_W-1:0]    first;
        logic [OFFS_W-1:0]    offset;
        logic                 single;
        logic [NUM_BANKS-1:0] lcdc;
    } t_map_res;

    // Per-bank hit and direct-mode flag
    typedef struct packed {
        logic hit;
        logic lcdc;
    } t_bank_res;

    // Wrap mask of a view; unknown views wrap to zero
    function automatic logic [ADDR_W-1:0] f_view_mask(input logic [VIEW_W-1:0] view);
        logic [ADDR_W-1:0] m;
        case (view)
            V_ABG, V_TEX:          m = 19'h7FFFF;
            V_AOBJ, V_ARM7:        m = SZ_256K - 19'd1;
            V_BBG, V_BOBJ, V_TPAL: m = SZ_128K - 19'd1;
            V_ABGX, V_BBGX:        m = SZ_32K - 19'd1;
            V_AOBJX, V_BOBJX:      m = SZ_8K - 19'd1;
            default:               m = '0;
        endcase
        return m;
    endfunction

    // Address mask of a bank's size
    function automatic logic [OFFS_W-1:0] f_bank_size_mask(input logic [BANK_W-1:0] bank);
        logic [OFFS_W-1:0] m;
        case (bank)
            BK_A, BK_B, BK_C, BK_D: m = 17'h1FFFF;
            BK_E:                   m = 17'h0FFFF;
            BK_H:                   m = 17'h07FFF;
            default:                m = 17'h03FFF;
        endcase
        return m;
    endfunction

    // Span length rounded up to whole blocks
    function automatic logic [ADDR_W-1:0] f_len_ru(input logic [ADDR_W-1:0] len);
        return (len + BLK_MASK) & ~BLK_MASK;
    endfunction

    // True when the wrapped span starting at base covers the aligned block address
    function automatic logic f_span(input logic               view_eq,
                                    input logic [ADDR_W-1:0] blk_addr,
                                    input logic [ADDR_W-1:0] vmask,
                                    input logic [ADDR_W-1:0] base,
                                    input logic [ADDR_W-1:0] len);
        logic [ADDR_W-1:0] span_dist;
        span_dist = (blk_addr - base) & vmask;
        return view_eq && (span_dist < f_len_ru(len));
    endfunction

endpackage

// ----- hdl/video_ram_bank_mapper_unit.sv -----
// A word accepted into the input register passes through the combinational
// decode into the result register, which drives the outputs.
// One word per cycle while the output is not stalled; the decode is a single
// pass between the input register and the result register, and a stage
// moves when the one after it has room. Reset clears both stage valid flags
// and the bank control registers, so all banks start disabled.
// Top level of the video RAM bank mapper: config registers and pipeline.
module video_ram_bank_mapper_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [vrbm_pkg::CFG_AE_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [vrbm_pkg::VIEW_W-1:0]     i_view_select,
    input  logic [vrbm_pkg::ADDR_W-1:0]     i_byte_address,
    // Output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [vrbm_pkg::NUM_BANKS-1:0]  o_bank_mask,
    output logic [vrbm_pkg::BANK_W-1:0]     o_first_bank,
    output logic [vrbm_pkg::OFFS_W-1:0]     o_bank_offset,
    output logic                            o_single_bank,
    output logic [vrbm_pkg::NUM_BANKS-1:0]  o_lcdc_banks
);

    logic [vrbm_pkg::CFG_AE_W-1:0]  r_ctl_ae;
    logic [vrbm_pkg::CFG_FI_W-1:0]  r_ctl_fi;
    logic                           r_s1_vld;
    logic [vrbm_pkg::VIEW_W-1:0]    r_view;
    logic [vrbm_pkg::ADDR_W-1:0]    r_addr;
    logic                           r_out_vld;
    vrbm_pkg::t_map_res             r_res;
    vrbm_pkg::t_map_res             n_res;
    vrbm_pkg::t_ctl                 ctl [vrbm_pkg::NUM_BANKS];
    logic                           out_load;
    logic                           in_acc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_ae <= '0;
            r_ctl_fi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vrbm_pkg::CFG_CTL_AE: r_ctl_ae <= i_cfg_data;
                vrbm_pkg::CFG_CTL_FI: r_ctl_fi <= i_cfg_data[vrbm_pkg::CFG_FI_W-1:0];
                default: ;
            endcase
        end
    end

    // Split the control registers into one byte per bank
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            ctl[i] = r_ctl_ae[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            ctl[5+i] = r_ctl_fi[8*i +: 8];
        end
    end

    // Pipeline flow control: a stage moves when the one after it has room
    assign out_load   = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !out_load;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_view <= i_view_select;
            r_addr <= i_byte_address;
        end
    end

    // Bank decode
    vrbm_decode u_decode (
        .i_view (r_view),
        .i_addr (r_addr),
        .i_ctl  (ctl),
        .o_res  (n_res)
    );

    // Result register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_vld) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_bank_mask   = r_res.mask;
    assign o_first_bank  = r_res.first;
    assign o_bank_offset = r_res.offset;
    assign o_single_bank = r_res.single;
    assign o_lcdc_banks  = r_res.lcdc;

    // The first bank is always a real bank index
    a_first_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_first_bank <= vrbm_pkg::BK_I))
        else $error("first bank index out of range");

    // A single-bank result names exactly the first bank
    a_single_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_single_bank) |->
            (o_bank_mask == (vrbm_pkg::NUM_BANKS'(1) << o_first_bank)))
        else $error("single bank flag disagrees with first bank");

    // An unmapped block reports zero bank and zero offset
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_bank_mask == '0)) |->
            (o_first_bank == '0 && o_bank_offset == '0 && !o_single_bank))
        else $error("unmapped result carries nonzero fields");

    // The input side only stalls while the result stage is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

// ----- hdl/vrbm_decode.sv -----
// Combinational bank decode: bank mask, first bank, offset and direct-mode set.
module vrbm_decode (
    input  logic [vrbm_pkg::VIEW_W-1:0]   i_view,
    input  logic [vrbm_pkg::ADDR_W-1:0]   i_addr,
    input  vrbm_pkg::t_ctl                i_ctl [vrbm_pkg::NUM_BANKS],
    output vrbm_pkg::t_map_res            o_res
);

    // Mapping rules of one bank for the current view and block
    function automatic vrbm_pkg::t_bank_res f_bank(
        input logic [vrbm_pkg::BANK_W-1:0] bank,
        input vrbm_pkg::t_ctl              cnt,
        input logic [vrbm_pkg::VIEW_W-1:0] view,
        input logic [vrbm_pkg::ADDR_W-1:0] ba,
        input logic [vrbm_pkg::ADDR_W-1:0] vm
    );
        vrbm_pkg::t_bank_res r;
        logic [2:0]                    mst;
        logic [1:0]                    ofs;
        logic [vrbm_pkg::ADDR_W-1:0]   b128;
        logic [vrbm_pkg::ADDR_W-1:0]   b128l;
        logic [vrbm_pkg::ADDR_W-1:0]   o;
        logic [vrbm_pkg::ADDR_W-1:0]   o16;
        logic v_abg, v_aobj, v_bbg, v_bobj, v_abgx, v_bbgx;
        logic v_aobjx, v_bobjx, v_tex, v_tpal, v_arm7;
        mst   = cnt[2:0];
        ofs   = cnt[4:3];
        b128  = vrbm_pkg::ADDR_W'(ofs) << 17;
        b128l = vrbm_pkg::ADDR_W'(ofs[0]) << 17;
        o16   = ofs[0] ? vrbm_pkg::SZ_16K : '0;
        o     = o16 | (ofs[1] ? vrbm_pkg::SZ_64K : '0);
        v_abg   = (view == vrbm_pkg::V_ABG);
        v_aobj  = (view == vrbm_pkg::V_AOBJ);
        v_bbg   = (view == vrbm_pkg::V_BBG);
        v_bobj  = (view == vrbm_pkg::V_BOBJ);
        v_abgx  = (view == vrbm_pkg::V_ABGX);
        v_bbgx  = (view == vrbm_pkg::V_BBGX);
        v_aobjx = (view == vrbm_pkg::V_AOBJX);
        v_bobjx = (view == vrbm_pkg::V_BOBJX);
        v_tex   = (view == vrbm_pkg::V_TEX);
        v_tpal  = (view == vrbm_pkg::V_TPAL);
        v_arm7  = (view == vrbm_pkg::V_ARM7);
        r = '0;
        case (bank)
            vrbm_pkg::BK_A, vrbm_pkg::BK_B: begin
                case (mst[1:0])
                    2'd0: r.lcdc = 1'b1;
                    2'd1: r.hit = vrbm_pkg::f_span(v_abg, ba, vm, b128, vrbm_pkg::SZ_128K);
                    2'd2: r.hit = vrbm_pkg::f_span(v_aobj, ba, vm, b128l, vrbm_pkg::SZ_128K);
                    default: r.hit = vrbm_pkg::f_span(v_tex, ba, vm, b128, vrbm_pkg::SZ_128K);
                endcase
            end
            vrbm_pkg::BK_C, vrbm_pkg::BK_D: begin
                case (mst)
                    3'd0: r.lcdc = 1'b1;
                    3'd1: r.hit = vrbm_pkg::f_span(v_abg, ba, vm, b128, vrbm_pkg::SZ_128K);
                    3'd2: r.hit = vrbm_pkg::f_span(v_arm7, ba, vm, b128l, vrbm_pkg::SZ_128K);
                    3'd3: r.hit = vrbm_pkg::f_span(v_tex, ba, vm, b128, vrbm_pkg::SZ_128K);
                    3'd4: r.hit = vrbm_pkg::f_span((bank == vrbm_pkg::BK_C) ? v_bbg : v_bobj,
                                                   ba, vm, '0, vrbm_pkg::SZ_128K);
                    default: r.hit = 1'b0;
                endcase
            end
            vrbm_pkg::BK_E: begin
                case (mst)
                    3'd0: r.lcdc = 1'b1;
                    3'd1: r.hit = vrbm_pkg::f_span(v_abg, ba, vm, '0, vrbm_pkg::SZ_64K);
                    3'd2: r.hit = vrbm_pkg::f_span(v_aobj, ba, vm, '0, vrbm_pkg::SZ_64K);
                    3'd3: r.hit = vrbm_pkg::f_span(v_tpal, ba, vm, '0, vrbm_pkg::SZ_64K);
                    3'd4: r.hit = vrbm_pkg::f_span(v_abgx, ba, vm, '0, vrbm_pkg::SZ_32K);
                    default: r.hit = 1'b0;
                endcase
            end
            vrbm_pkg::BK_F, vrbm_pkg::BK_G: begin
                case (mst)
                    3'd0: r.lcdc = 1'b1;
                    3'd1: r.hit = vrbm_pkg::f_span(v_abg, ba, vm, o, vrbm_pkg::SZ_16K) ||
                                  vrbm_pkg::f_span(v_abg, ba, vm, o + vrbm_pkg::SZ_32K,
                                                   vrbm_pkg::SZ_16K);
                    3'd2: r.hit = vrbm_pkg::f_span(v_aobj, ba, vm, o, vrbm_pkg::SZ_16K) ||
                                  vrbm_pkg::f_span(v_aobj, ba, vm, o + vrbm_pkg::SZ_32K,
                                                   vrbm_pkg::SZ_16K);
                    3'd3: r.hit = vrbm_pkg::f_span(v_tpal, ba, vm, o, vrbm_pkg::SZ_16K);
                    3'd4: r.hit = vrbm_pkg::f_span(v_abgx, ba, vm, o16, vrbm_pkg::SZ_16K);
                    3'd5: r.hit = vrbm_pkg::f_span(v_aobjx, ba, vm, '0, vrbm_pkg::SZ_8K);
                    default: r.hit = 1'b0;
                endcase
            end
            vrbm_pkg::BK_H: begin
                case (mst[1:0])
                    2'd0: r.lcdc = 1'b1;
                    2'd1: r.hit = vrbm_pkg::f_span(v_bbg, ba, vm, '0, vrbm_pkg::SZ_32K) ||
                                  vrbm_pkg::f_span(v_bbg, ba, vm, vrbm_pkg::SZ_64K,
                                                   vrbm_pkg::SZ_32K);
                    2'd2: r.hit = vrbm_pkg::f_span(v_bbgx, ba, vm, '0, vrbm_pkg::SZ_32K);
                    default: r.hit = 1'b0;
                endcase
            end
            default: begin
                case (mst[1:0])
                    2'd0: r.lcdc = 1'b1;
                    2'd1: r.hit =
                        vrbm_pkg::f_span(v_bbg, ba, vm, vrbm_pkg::SZ_32K, vrbm_pkg::SZ_16K) ||
                        vrbm_pkg::f_span(v_bbg, ba, vm, vrbm_pkg::SZ_48K, vrbm_pkg::SZ_16K) ||
                        vrbm_pkg::f_span(v_bbg, ba, vm, vrbm_pkg::SZ_96K, vrbm_pkg::SZ_16K) ||
                        vrbm_pkg::f_span(v_bbg, ba, vm, vrbm_pkg::SZ_112K, vrbm_pkg::SZ_16K);
                    2'd2: r.hit = vrbm_pkg::f_span(v_bobj, ba, vm, '0, vrbm_pkg::SZ_128K);
                    default: r.hit = vrbm_pkg::f_span(v_bobjx, ba, vm, '0, vrbm_pkg::SZ_8K);
                endcase
            end
        endcase
        return r;
    endfunction

    logic [vrbm_pkg::ADDR_W-1:0]    vmask;
    logic [vrbm_pkg::ADDR_W-1:0]    addr_w;
    logic [vrbm_pkg::ADDR_W-1:0]    blk_addr;
    logic [vrbm_pkg::NUM_BANKS-1:0] mask;
    logic [vrbm_pkg::NUM_BANKS-1:0] lcdc;
    logic [vrbm_pkg::BANK_W-1:0]    first;
    vrbm_pkg::t_bank_res            bres [vrbm_pkg::NUM_BANKS];

    // Wrap the address to the view and align it to its block
    assign vmask    = vrbm_pkg::f_view_mask(i_view);
    assign addr_w   = i_addr & vmask;
    assign blk_addr = addr_w & ~vrbm_pkg::BLK_MASK;

    // Apply each enabled bank's rules in parallel
    always_comb begin
        for (int i = 0; i < vrbm_pkg::NUM_BANKS; i++) begin
            bres[i] = f_bank(vrbm_pkg::BANK_W'(i), i_ctl[i], i_view, blk_addr, vmask);
            mask[i] = i_ctl[i][7] & bres[i].hit;
            lcdc[i] = i_ctl[i][7] & bres[i].lcdc;
        end
    end

    // Lowest mapped bank
    always_comb begin
        first = '0;
        for (int i = vrbm_pkg::NUM_BANKS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                first = vrbm_pkg::BANK_W'(i);
            end
        end
    end

    // Assemble the result word
    always_comb begin
        o_res.mask   = mask;
        o_res.first  = first;
        o_res.offset = (mask != '0) ?
                       (addr_w[vrbm_pkg::OFFS_W-1:0] & vrbm_pkg::f_bank_size_mask(first)) : '0;
        o_res.single = (mask != '0) && ((mask & (mask - 9'd1)) == '0);
        o_res.lcdc   = lcdc;
    end

endmodule
